@@ rtl/core/nkr_pkg.sv @@
// ----------------------------------------------------------------------------
// nkr_pkg
// Shared types, keyword codes and pattern tables of the numeric keyword
// recognizer.
// ----------------------------------------------------------------------------
package nkr_pkg;

  localparam int NUM_PAT  = 11;
  localparam int CHAR_W   = 8;
  localparam int CNT_W    = 4;
  localparam int KW_W     = 4;
  localparam int MAX_LEN  = 10;

  // keyword codes
  localparam logic [KW_W-1:0] KW_NONE    = 4'd0;
  localparam logic [KW_W-1:0] KW_MIN     = 4'd1;
  localparam logic [KW_W-1:0] KW_MAX     = 4'd2;
  localparam logic [KW_W-1:0] KW_DEFAULT = 4'd3;
  localparam logic [KW_W-1:0] KW_PINF    = 4'd4;
  localparam logic [KW_W-1:0] KW_NINF    = 4'd5;
  localparam logic [KW_W-1:0] KW_NAN     = 4'd6;
  localparam logic [KW_W-1:0] KW_UP      = 4'd7;
  localparam logic [KW_W-1:0] KW_DOWN    = 4'd8;

  // pattern text, right aligned: first character sits in the highest used byte
  localparam logic [8*MAX_LEN-1:0] PAT_TEXT [NUM_PAT] = '{
    "+INFINITY", "-INFINITY", "MINIMUM", "MAXIMUM", "DEFAULT",
    "INFINITY", "NINFINITY", "NOTANUMBER", "NAN", "UP", "DOWN"
  };

  localparam int PAT_LEN [NUM_PAT] = '{9, 9, 7, 7, 7, 8, 9, 10, 3, 2, 4};

  // bit n set: a still-matching token of length n is accepted
  localparam logic [15:0] PAT_ACCEPT [NUM_PAT] = '{
    16'h0210, 16'h0210, 16'h00F8, 16'h00F8, 16'h00F8, 16'h01F8,
    16'h03F0, 16'h07F0, 16'h0008, 16'h0004, 16'h0010
  };

  localparam logic [KW_W-1:0] PAT_CODE [NUM_PAT] = '{
    KW_PINF, KW_NINF, KW_MIN, KW_MAX, KW_DEFAULT, KW_PINF,
    KW_NINF, KW_NAN, KW_NAN, KW_UP, KW_DOWN
  };

  localparam logic [NUM_PAT-1:0] ALL_FLAGS = '1;

  // character i of pattern p (only meaningful for i below the pattern length)
  function automatic logic [CHAR_W-1:0] pat_byte(input int p, input int i);
    logic [8*MAX_LEN-1:0] txt;
    txt = PAT_TEXT[p] << (8 * (MAX_LEN - PAT_LEN[p]));
    return txt[8*MAX_LEN-1-8*i -: 8];
  endfunction

  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    logic [NUM_PAT-1:0] flags;
  } nkr_state_t;

endpackage

@@ rtl/core/nkr_step.sv @@
// ----------------------------------------------------------------------------
// nkr_step
// One character of update: case fold, per-pattern compare, saturating count,
// and the priority judge on the updated state.
// ----------------------------------------------------------------------------
module nkr_step
  import nkr_pkg::*;
(
  input  nkr_state_t        state_cur,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              has_char,
  output nkr_state_t        state_nxt,
  output logic [KW_W-1:0]   keyword
);

  logic [CHAR_W-1:0] ch_up;
  logic [NUM_PAT-1:0] hit;

  // fold a-z only
  always_comb begin
    if (char_code inside {[8'h61:8'h7A]}) begin
      ch_up = char_code - 8'h20;
    end else begin
      ch_up = char_code;
    end
  end

  always_comb begin
    logic [CHAR_W-1:0] exp_ch;
    for (int p = 0; p < NUM_PAT; p++) begin
      exp_ch = '0;
      for (int i = 0; i < MAX_LEN; i++) begin
        if (i < PAT_LEN[p] && state_cur.cnt == CNT_W'(i)) begin
          exp_ch = pat_byte(p, i);
        end
      end
      hit[p] = (32'(state_cur.cnt) < PAT_LEN[p]) && (exp_ch == ch_up);
    end
  end

  always_comb begin
    state_nxt = state_cur;
    if (has_char) begin
      state_nxt.flags = state_cur.flags & hit;
      if (state_cur.cnt != '1) begin
        state_nxt.cnt = state_cur.cnt + 1'b1;
      end
    end
  end

  // lowest-indexed passing pattern wins
  always_comb begin
    keyword = KW_NONE;
    for (int p = NUM_PAT - 1; p >= 0; p--) begin
      if (state_nxt.flags[p] && PAT_ACCEPT[p][state_nxt.cnt]) begin
        keyword = PAT_CODE[p];
      end
    end
  end

endmodule

@@ rtl/core/numeric_keyword_recognizer_unit.sv @@
// ----------------------------------------------------------------------------
// numeric_keyword_recognizer_unit
// Character stream recognizer for numeric keywords (MIN, MAX, DEF, INF,
// NAN, UP, DOWN and their long forms), one verdict per token.
// ----------------------------------------------------------------------------
// verdict path: a beat marked tlast goes from the input register into the
//   result register once that is free, and its verdict shows on out_*
// throughput: one input beat per cycle unless a tlast beat waits on a full
//   result register; match state: a single register, updated by one nkr_step
// reset: synchronous active-low rst_n clears both valid flags and sets the
//   match state to count zero, all patterns still matching
module numeric_keyword_recognizer_unit
  import nkr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_code
  input  logic              in_tuser,   // [0] has_char
  input  logic              in_tlast,   // last character of the token
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [3:0] keyword, [7:4] zero
  output logic              out_tuser   // [0] is_keyword
);

  // input register
  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_has_r;
  logic              s1_last_r;
  logic              s1_move;

  // token state and result register
  nkr_state_t        state_r;
  nkr_state_t        state_nxt;
  logic [KW_W-1:0]   kw_nxt;
  logic              out_valid_r;
  logic [KW_W-1:0]   out_kw_r;

  // a beat leaves the input register when it makes no result, or when the
  // result register is free or being drained this cycle
  assign s1_move   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_has_r  <= in_tuser;
      s1_last_r <= in_tlast;
    end
  end

  nkr_step u_step (
    .state_cur (state_r),
    .char_code (s1_char_r),
    .has_char  (s1_has_r),
    .state_nxt (state_nxt),
    .keyword   (kw_nxt)
  );

  // token state: update per beat, back to reset after the closing beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.cnt   <= '0;
      state_r.flags <= ALL_FLAGS;
    end else if (s1_move) begin
      if (s1_last_r) begin
        state_r.cnt   <= '0;
        state_r.flags <= ALL_FLAGS;
      end else begin
        state_r <= state_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_last_r) begin
      out_kw_r <= kw_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - KW_W){1'b0}}, out_kw_r};
  assign out_tuser  = (out_kw_r != KW_NONE);

`ifndef SYNTHESIS
  // an empty count means a fresh token: every pattern still alive
  a_fresh_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.cnt == '0) |-> (state_r.flags == ALL_FLAGS))
    else $error("fresh token with cleared match flags");

  // closing beat returns the token state to its start
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_last_r) |=> (state_r.cnt == '0))
    else $error("token state not cleared after closing beat");

  // a closing beat never overwrites a result that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_last_r && out_valid_r) |-> out_tready)
    else $error("result register overrun");

  // verdict code stays within the keyword range
  a_kw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kw_r <= KW_DOWN))
    else $error("keyword code out of range");
`endif

endmodule
